FILE: hw/rtl/assert_macros.svh
// assertion macros used by ufph_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UFPH_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define UFPH_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ufph_pkg.sv
// ----------------------------------------------------------------------------
// ufph_pkg
// shared constants, control structs and index helper for the union-find block
// ----------------------------------------------------------------------------
`default_nettype none

package ufph_pkg;

	// default forest size
	localparam int NODES_DEF = 1024;

	// width of the node index fields on the channels
	localparam int IDX_FIELD_W = 10;

	// write enables from the controller to the table store
	typedef struct packed {
		logic par_we;
		logic size_we;
	} ufph_wr_t;

	// status from the table store
	typedef struct packed {
		logic clearing;
	} ufph_stat_t;

	// saturate an index field to the last valid node
	function automatic logic [IDX_FIELD_W-1:0] bound_index(
		input logic [IDX_FIELD_W-1:0] v,
		input logic [IDX_FIELD_W-1:0] lim
	);
		return (v > lim) ? lim : v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ufph_ifs.sv
// ----------------------------------------------------------------------------
// ufph channel interfaces
// valid/ready channels for node pairs in and joined pairs out
// ----------------------------------------------------------------------------
`default_nettype none

interface ufph_pair_if;
	logic valid;
	logic ready;
	logic [ufph_pkg::IDX_FIELD_W-1:0] first_node;
	logic [ufph_pkg::IDX_FIELD_W-1:0] second_node;

	modport source(output valid, output first_node, output second_node, input ready);
	modport sink(input valid, input first_node, input second_node, output ready);
endinterface

interface ufph_join_if;
	logic valid;
	logic ready;
	logic [ufph_pkg::IDX_FIELD_W-1:0] first_node_out;
	logic [ufph_pkg::IDX_FIELD_W-1:0] second_node_out;

	modport source(output valid, output first_node_out, output second_node_out, input ready);
	modport sink(input valid, input first_node_out, input second_node_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ufph_store.sv
// ----------------------------------------------------------------------------
// ufph_store
// parent and tree-size memories, one write and one registered read port each,
// with the post-reset clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module ufph_store #(
	parameter int NODES = ufph_pkg::NODES_DEF,
	localparam int AW = $clog2(NODES),
	localparam int SW = $clog2(NODES) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ufph_pkg::ufph_wr_t   wr,
	input  logic [AW-1:0]        par_waddr,
	input  logic [AW-1:0]        par_wdata,
	input  logic [AW-1:0]        size_waddr,
	input  logic [SW-1:0]        size_wdata,
	input  logic [AW-1:0]        par_raddr,
	input  logic [AW-1:0]        size_raddr,
	output logic [AW-1:0]        par_rdata,
	output logic [SW-1:0]        size_rdata,
	output ufph_pkg::ufph_stat_t stat
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(NODES - 1);

	logic [AW-1:0] par_mem  [NODES];
	logic [SW-1:0] size_mem [NODES];

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] par_rdata_q;
	logic [SW-1:0] size_rdata_q;

	logic          par_we;
	logic          size_we;
	logic [AW-1:0] par_wa;
	logic [AW-1:0] par_wd;
	logic [AW-1:0] size_wa;
	logic [SW-1:0] size_wd;

	// clearing sweep, one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// write port select: sweep or controller
	always_comb begin
		if (clearing_q) begin
			par_we  = 1'b1;
			size_we = 1'b1;
			par_wa  = clr_addr_q;
			par_wd  = clr_addr_q;
			size_wa = clr_addr_q;
			size_wd = SW'(1);
		end else begin
			par_we  = wr.par_we;
			size_we = wr.size_we;
			par_wa  = par_waddr;
			par_wd  = par_wdata;
			size_wa = size_waddr;
			size_wd = size_wdata;
		end
	end

	// parent memory
	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rdata_q <= par_mem[par_raddr];
	end

	// tree-size memory
	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		size_rdata_q <= size_mem[size_raddr];
	end

	assign par_rdata     = par_rdata_q;
	assign size_rdata    = size_rdata_q;
	assign stat.clearing = clearing_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ufph_ctrl.sv
// ----------------------------------------------------------------------------
// ufph_ctrl
// sequencer for root walks with path halving, size compare and linking
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ufph_ctrl #(
	parameter int NODES = ufph_pkg::NODES_DEF,
	localparam int AW = $clog2(NODES),
	localparam int SW = $clog2(NODES) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ufph_pair_if.sink            pair,
	ufph_join_if.source          joined,
	output ufph_pkg::ufph_wr_t   wr,
	output logic [AW-1:0]        par_waddr,
	output logic [AW-1:0]        par_wdata,
	output logic [SW-1:0]        size_wdata,
	output logic [AW-1:0]        size_waddr,
	output logic [AW-1:0]        par_raddr,
	output logic [AW-1:0]        size_raddr,
	input  logic [AW-1:0]        par_rdata,
	input  logic [SW-1:0]        size_rdata,
	input  ufph_pkg::ufph_stat_t stat
);

	localparam int FW = ufph_pkg::IDX_FIELD_W;
	localparam int LIM_INT = (NODES - 1 > (1 << FW) - 1) ? (1 << FW) - 1 : NODES - 1;
	localparam logic [FW-1:0] IDX_LIM = FW'(LIM_INT);
	localparam logic [SW:0] NODES_V = (SW + 1)'(NODES);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FIND_P = 3'd1;
	localparam logic [2:0] S_FIND_G = 3'd2;
	localparam logic [2:0] S_SIZE_A = 3'd3;
	localparam logic [2:0] S_SIZE_B = 3'd4;
	localparam logic [2:0] S_LINK   = 3'd5;

	logic [2:0]    state_q;
	logic          phase_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] ra_q;
	logic [AW-1:0] rb_q;
	logic [FW-1:0] node_a_q;
	logic [FW-1:0] node_b_q;
	logic [SW-1:0] sa_q;
	logic [SW-1:0] sb_q;
	logic          out_valid_q;
	logic [FW-1:0] out_a_q;
	logic [FW-1:0] out_b_q;

	logic          accept;
	logic          slot_free;
	logic          at_root;
	logic          a_smaller;
	logic [SW-1:0] size_sum;
	logic [FW-1:0] bnd_a;
	logic [FW-1:0] bnd_b;

	assign pair.ready = (state_q == S_IDLE) && !stat.clearing;
	assign accept     = pair.valid && pair.ready;
	assign slot_free  = !out_valid_q || joined.ready;
	assign at_root    = (par_rdata == cur_q);
	assign a_smaller  = (sa_q < sb_q);
	assign size_sum   = SW'(sa_q + sb_q);
	assign bnd_a      = ufph_pkg::bound_index(pair.first_node, IDX_LIM);
	assign bnd_b      = ufph_pkg::bound_index(pair.second_node, IDX_LIM);

	// memory addressing and write-back per state
	always_comb begin
		wr         = '0;
		par_raddr  = cur_q;
		size_raddr = ra_q;
		par_waddr  = cur_q;
		par_wdata  = par_rdata;
		size_waddr = ra_q;
		size_wdata = size_sum;
		unique case (state_q)
			S_IDLE: begin
				par_raddr = AW'(bnd_a);
			end
			S_FIND_P: begin
				if (!at_root) begin
					par_raddr = par_rdata;
				end else if (!phase_q) begin
					par_raddr = AW'(node_b_q);
				end
			end
			S_FIND_G: begin
				// halving: point current node at its grandparent
				wr.par_we = 1'b1;
				par_raddr = par_rdata;
			end
			S_SIZE_A: begin
				size_raddr = rb_q;
			end
			S_SIZE_B: begin
			end
			S_LINK: begin
				if (slot_free) begin
					wr.par_we  = 1'b1;
					wr.size_we = 1'b1;
					if (a_smaller) begin
						par_waddr  = ra_q;
						par_wdata  = rb_q;
						size_waddr = rb_q;
					end else begin
						par_waddr  = rb_q;
						par_wdata  = ra_q;
						size_waddr = ra_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= 1'b0;
						state_q <= S_FIND_P;
					end
				end
				S_FIND_P: begin
					if (!at_root) begin
						state_q <= S_FIND_G;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (cur_q == ra_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SIZE_A;
					end
				end
				S_FIND_G: begin
					state_q <= S_FIND_P;
				end
				S_SIZE_A: begin
					state_q <= S_SIZE_B;
				end
				S_SIZE_B: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					node_a_q <= bnd_a;
					node_b_q <= bnd_b;
					cur_q    <= AW'(bnd_a);
				end
			end
			S_FIND_P: begin
				if (at_root) begin
					if (!phase_q) begin
						ra_q  <= cur_q;
						cur_q <= AW'(node_b_q);
					end else begin
						rb_q <= cur_q;
					end
				end
			end
			S_FIND_G: begin
				cur_q <= par_rdata;
			end
			S_SIZE_A: begin
				sa_q <= size_rdata;
			end
			S_SIZE_B: begin
				sb_q <= size_rdata;
			end
			default: begin
			end
		endcase
	end

	// output register, holds a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_LINK && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (joined.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LINK && slot_free) begin
			out_a_q <= node_a_q;
			out_b_q <= node_b_q;
		end
	end

	assign joined.valid           = out_valid_q;
	assign joined.first_node_out  = out_a_q;
	assign joined.second_node_out = out_b_q;

	// checks
	`UFPH_ASSERT_IMPL(a_no_ctrl_wr_clear, clk, arst_n, wr.par_we || wr.size_we,
		!stat.clearing, "controller write during clearing sweep")
	`UFPH_ASSERT_IMPL(a_halving_acyclic, clk, arst_n, state_q == S_FIND_G,
		par_rdata != cur_q, "grandparent equals walked node")
	`UFPH_ASSERT_IMPL(a_link_distinct, clk, arst_n, state_q == S_LINK,
		(ra_q != rb_q) && (({1'b0, sa_q} + {1'b0, sb_q}) <= NODES_V),
		"link of equal roots or size overflow")
	`UFPH_ASSERT_NEXT(a_link_emits, clk, arst_n, state_q == S_LINK && slot_free,
		joined.valid && state_q == S_IDLE, "link without joined beat")

endmodule

`default_nettype wire

FILE: hw/rtl/union_find_path_halving_top.sv
// flow: root walk of the first node, then of the second, halving along the way; a pair
//   in two sets then reads both root sizes and links them, with a beat out
// throughput: one pair at a time; each halving step takes a parent read, then a
//   grandparent read with write-back, on the parent memory read port
// reset: a clearing sweep sets every parent to itself and every size to one;
//   pairs are taken only after it ends
`default_nettype none

// ----------------------------------------------------------------------------
// union_find_path_halving_top
// disjoint-set forest with weighted union and path halving over memory tables
// ----------------------------------------------------------------------------
module union_find_path_halving_top #(
	parameter int NODES = ufph_pkg::NODES_DEF,
	localparam int AW = $clog2(NODES),
	localparam int SW = $clog2(NODES) + 1
) (
	input logic         clk,
	input logic         arst_n,
	ufph_pair_if.sink   pair,
	ufph_join_if.source joined
);

	ufph_pkg::ufph_wr_t   wr;
	ufph_pkg::ufph_stat_t stat;
	logic [AW-1:0]        par_waddr;
	logic [AW-1:0]        par_wdata;
	logic [AW-1:0]        size_waddr;
	logic [SW-1:0]        size_wdata;
	logic [AW-1:0]        par_raddr;
	logic [AW-1:0]        size_raddr;
	logic [AW-1:0]        par_rdata;
	logic [SW-1:0]        size_rdata;

	// table memories
	ufph_store #(
		.NODES(NODES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.par_waddr (par_waddr),
		.par_wdata (par_wdata),
		.size_waddr(size_waddr),
		.size_wdata(size_wdata),
		.par_raddr (par_raddr),
		.size_raddr(size_raddr),
		.par_rdata (par_rdata),
		.size_rdata(size_rdata),
		.stat      (stat)
	);

	// walk and link sequencer
	ufph_ctrl #(
		.NODES(NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.joined    (joined),
		.wr        (wr),
		.par_waddr (par_waddr),
		.par_wdata (par_wdata),
		.size_wdata(size_wdata),
		.size_waddr(size_waddr),
		.par_raddr (par_raddr),
		.size_raddr(size_raddr),
		.par_rdata (par_rdata),
		.size_rdata(size_rdata),
		.stat      (stat)
	);

endmodule

`default_nettype wire

FILE: sim/union_find_path_halving_top_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// union_find_path_halving_top_test
// drives node pairs into the disjoint-set block and checks every joined pair
// against a local forest that does the same weighted union and path halving
// ----------------------------------------------------------------------------
module union_find_path_halving_top_test;

	localparam int NODES = ufph_pkg::NODES_DEF;
	localparam int IW = ufph_pkg::IDX_FIELD_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef logic [IW-1:0] node_t;
	typedef logic [IW:0] weight_t;

	typedef struct {
		node_t first;
		node_t second;
	} join_beat_t;

	logic clk;
	logic arst_n;

	ufph_pair_if pair_ch ();
	ufph_join_if join_ch ();

	union_find_path_halving_top #(
		.NODES(NODES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair_ch),
		.joined(join_ch)
	);

	// local copy of the forest
	node_t forest_parent [NODES];
	weight_t forest_weight [NODES];
	join_beat_t pending_joins [$];

	int errors = 0;
	bit steady = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// index saturation to the last node
	function automatic node_t clamp_node(input node_t v);
		return (int'(v) > NODES - 1) ? node_t'(NODES - 1) : v;
	endfunction

	// root walk that points each visited node at its grandparent
	function automatic node_t climb_and_halve(input node_t n);
		node_t cur;
		node_t up;
		int steps;
		cur = n;
		steps = 0;
		while (forest_parent[cur] != cur && steps < NODES) begin
			up = forest_parent[cur];
			forest_parent[cur] = forest_parent[up];
			cur = forest_parent[cur];
			steps++;
		end
		return cur;
	endfunction

	// apply one accepted pair to the local forest
	function automatic void absorb_pair(input node_t a_in, input node_t b_in);
		node_t a;
		node_t b;
		node_t ra;
		node_t rb;
		join_beat_t jb;
		a = clamp_node(a_in);
		b = clamp_node(b_in);
		ra = climb_and_halve(a);
		rb = climb_and_halve(b);
		if (ra == rb)
			return;
		if (forest_weight[ra] < forest_weight[rb]) begin
			forest_parent[ra] = rb;
			forest_weight[rb] = forest_weight[rb] + forest_weight[ra];
		end else begin
			forest_parent[rb] = ra;
			forest_weight[ra] = forest_weight[ra] + forest_weight[rb];
		end
		jb.first = a;
		jb.second = b;
		pending_joins.push_back(jb);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// forest reset state
	initial begin
		for (int k = 0; k < NODES; k++) begin
			forest_parent[k] = node_t'(k);
			forest_weight[k] = weight_t'(1);
		end
	end

	// predict on every accepted pair
	always @(posedge clk) begin
		if (arst_n && pair_ch.valid && pair_ch.ready)
			absorb_pair(pair_ch.first_node, pair_ch.second_node);
	end

	// compare every joined beat with the oldest prediction
	always @(posedge clk) begin
		join_beat_t want;
		if (arst_n && join_ch.valid && join_ch.ready) begin
			if (pending_joins.size() == 0) begin
				report_mismatch("unexpected join, first_node_out", join_ch.first_node_out, -1);
			end else begin
				want = pending_joins.pop_front();
				if (join_ch.first_node_out !== want.first)
					report_mismatch("first_node_out", join_ch.first_node_out, want.first);
				if (join_ch.second_node_out !== want.second)
					report_mismatch("second_node_out", join_ch.second_node_out, want.second);
			end
		end
	end

	// receiver with random stalls and a counted hold-off
	initial begin
		join_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				join_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				join_ch.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				join_ch.ready <= 1'b1;
			end else begin
				join_ch.ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((pair_ch.valid && pair_ch.ready) || (join_ch.valid && join_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d joins pending", pending_joins.size());
			$display("FAIL");
			$finish;
		end
	end

	// one pair beat; called and returns at a rising edge
	task automatic send_pair(input node_t a, input node_t b);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 31)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			pair_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_ch.valid <= 1'b1;
		pair_ch.first_node <= a;
		pair_ch.second_node <= b;
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
	endtask

	// stop sending until every join is back and the last walk is over
	task automatic drain_joins();
		pair_ch.valid <= 1'b0;
		while (pending_joins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// node near a cluster base, sometimes anywhere
	function automatic node_t cluster_node(input int base, input int span);
		int v;
		if ($urandom_range(99) < 15)
			return node_t'($urandom_range(NODES - 1));
		v = base + $urandom_range(span - 1);
		return node_t'((v > NODES - 1) ? NODES - 1 : v);
	endfunction

	// extremes, self pairs, same set, both weight orders, ties
	task automatic test_directed();
		send_pair(0, 1023);
		send_pair(1023, 0);
		send_pair(5, 5);
		send_pair(1023, 1023);
		send_pair(1, 2);
		send_pair(3, 1);
		send_pair(1, 0);
		send_pair(4, 6);
		send_pair(7, 8);
		send_pair(4, 7);
		send_pair(9, 4);
		send_pair(1023, 4);
		send_pair(2, 8);
		send_pair(9, 3);
		send_pair(512, 511);
		send_pair(682, 341);
		send_pair(341, 682);
		send_pair(10, 11);
		send_pair(12, 10);
		send_pair(11, 6);
		drain_joins();
	endtask

	// clustered pairs so trees grow deep and repeat pairs hit one set
	task automatic test_random_clusters(input int count);
		int base;
		int span;
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			base = $urandom_range(NODES - 1);
			span = $urandom_range(2, 48);
			burst = $urandom_range(10, 60);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_pair(cluster_node(base, span), cluster_node(base, span));
				left--;
			end
		end
		drain_joins();
	endtask

	// uniform pairs over the whole index range
	task automatic test_random_wide(input int count);
		for (int k = 0; k < count; k++)
			send_pair(node_t'($urandom_range(NODES - 1)), node_t'($urandom_range(NODES - 1)));
		drain_joins();
	endtask

	// no idling on either side
	task automatic test_steady_stream(input int count);
		steady = 1;
		test_random_wide(count);
		steady = 0;
	endtask

	// receiver holds off while pairs keep coming
	task automatic test_backpressure(input int count);
		int base;
		hold_left = HOLD_OFF_CYCLES;
		steady = 1;
		base = $urandom_range(NODES - 1);
		for (int k = 0; k < count; k++)
			send_pair(cluster_node(base, 64), node_t'($urandom_range(NODES - 1)));
		steady = 0;
		drain_joins();
	endtask

	// reset, then the tests in turn
	initial begin
		arst_n = 1'b0;
		pair_ch.valid = 1'b0;
		pair_ch.first_node = '0;
		pair_ch.second_node = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_clusters(900);
		test_backpressure(60);
		test_steady_stream(200);
		test_random_clusters(300);
		test_random_wide(220);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ufph_pkg.sv
hw/rtl/ufph_ifs.sv
hw/rtl/ufph_store.sv
hw/rtl/ufph_ctrl.sv
hw/rtl/union_find_path_halving_top.sv
sim/union_find_path_halving_top_test.sv
